>>> rtl/lbq_pkg.sv
// Package for the level bucket queue: widths, types, codes and state encoding.
package lbq_pkg;

  localparam int LEVELS   = 64;
  localparam int CAPACITY = 256;
  localparam int ID_WIDTH = 16;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef logic [LVL_W-1:0]    lvl_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [LEVELS-1:0]   map_t;

  localparam lvl_t TOP_LEVEL_RST = lvl_t'(LEVELS - 1);

  typedef enum logic [1:0] {
    REQ_PUT      = 2'd0,
    REQ_TAKE_MIN = 2'd1,
    REQ_TAKE_MAX = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_PUT_OK = 3'd0,
    ST_TAKEN  = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_FULL   = 3'd3,
    ST_RANGE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PUT_WR,
    S_TAKE_HT,
    S_TAKE_ID,
    S_TAKE_WR
  } state_t;

endpackage

>>> rtl/lbq_in_if.sv
// Request channel of the level bucket queue.
interface lbq_in_if;
  logic              valid;
  logic              ready;
  lbq_pkg::req_t     req_type;
  lbq_pkg::lvl_t     item_level;
  lbq_pkg::id_t      item_id;

  modport source (output valid, output req_type, output item_level, output item_id,
                  input ready);
  modport sink   (input valid, input req_type, input item_level, input item_id,
                  output ready);
endinterface

>>> rtl/lbq_out_if.sv
// Result channel of the level bucket queue.
interface lbq_out_if;
  logic              valid;
  logic              ready;
  lbq_pkg::status_t  status;
  lbq_pkg::id_t      out_id;
  lbq_pkg::lvl_t     out_level;
  lbq_pkg::cnt_t     item_count;

  modport source (output valid, output status, output out_id, output out_level,
                  output item_count, input ready);
  modport sink   (input valid, input status, input out_id, input out_level,
                  input item_count, output ready);
endinterface

>>> rtl/level_bucket_queue.sv
// Level bucket queue: per-level FIFO lists over a shared linked-entry store.
//
// Usage: requests arrive on in_ch (put, take minimum, take maximum, clear) and
// each one gives exactly one result beat on out_ch with a status, the taken
// identifier and level (zero when nothing is taken) and the count held after it.
// cfg_we/cfg_wdata write top_level, the highest level a put may use; write it
// only while no request is in flight.
// Timing: in_ch.ready is high only while the sequencer is idle. An accepted
// request goes to the decode step, where a clear or a rejected request loads
// its result; a put loads it in the put write step, and a take passes through
// the head and tail read and the id read steps and loads it in the write step.
// The next request is accepted only once the sequencer is back in idle. The
// take path is set by the chain of registered reads: the level scan, then the
// level's head and tail, then the entry's id and link, then the write-back.
// Reset: rst_n (synchronous) empties the queue, rebuilds the free chain by
// clearing all the link valid bits together, and sets top_level to its highest
// value. No clearing pass is needed.
// Stall: a result waits in the output register; the sequencer holds in its
// final step, with no state changed, until that register is free.
module level_bucket_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  lbq_pkg::lvl_t    cfg_wdata,
  lbq_in_if.sink           in_ch,
  lbq_out_if.source        out_ch
);

  // sequencer and request
  lbq_pkg::state_t state_r, state_nxt;
  lbq_pkg::req_t   req_r;
  lbq_pkg::lvl_t   lvl_r;
  lbq_pkg::id_t    id_r;
  lbq_pkg::lvl_t   top_level_r;

  // queue bookkeeping
  lbq_pkg::map_t   bitmap_r, bitmap_nxt;
  lbq_pkg::cnt_t   held_count_r, held_count_nxt;
  lbq_pkg::lvl_t   low_r, low_nxt;
  lbq_pkg::lvl_t   high_r, high_nxt;
  lbq_pkg::slot_t  free_head_r, free_head_nxt;
  lbq_pkg::lvl_t   found_r;

  // result register
  logic              out_valid_r;
  lbq_pkg::status_t  status_r, status_nxt;
  lbq_pkg::id_t      oid_r, oid_nxt;
  lbq_pkg::lvl_t     olvl_r, olvl_nxt;
  lbq_pkg::cnt_t     ocnt_r, ocnt_nxt;
  logic              res_load;
  logic              out_free;

  // memories
  lbq_pkg::id_t    ids_mem  [lbq_pkg::CAPACITY];
  lbq_pkg::slot_t  next_mem [lbq_pkg::CAPACITY];
  lbq_pkg::slot_t  head_mem [lbq_pkg::LEVELS];
  lbq_pkg::slot_t  tail_mem [lbq_pkg::LEVELS];
  logic [lbq_pkg::CAPACITY-1:0] next_vld_r;

  lbq_pkg::id_t    ids_rd_r;
  lbq_pkg::slot_t  next_rd_r;
  logic            next_vld_rd_r;
  lbq_pkg::slot_t  next_raddr_r;
  lbq_pkg::slot_t  head_rd_r;
  lbq_pkg::slot_t  tail_rd_r;

  lbq_pkg::slot_t  next_raddr;
  lbq_pkg::lvl_t   ht_raddr;
  lbq_pkg::slot_t  next_link;

  logic            ids_we;
  lbq_pkg::slot_t  ids_waddr;
  logic            next_we;
  lbq_pkg::slot_t  next_waddr;
  lbq_pkg::slot_t  next_wdata;
  logic            head_we;
  lbq_pkg::lvl_t   head_waddr;
  lbq_pkg::slot_t  head_wdata;
  logic            tail_we;
  logic            vld_clear;

  // shared scan unit
  lbq_pkg::map_t   scan_in;
  lbq_pkg::lvl_t   scan_idx;
  lbq_pkg::lvl_t   scan_lvl;

  logic            put_range;
  logic            put_full;
  logic            in_fire;
  logic            take_commit;

  assign in_ch.ready = (state_r == lbq_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign put_range   = (lvl_r > top_level_r);
  assign put_full    = (held_count_r >= lbq_pkg::cnt_t'(lbq_pkg::CAPACITY));
  assign take_commit = (state_r == lbq_pkg::S_TAKE_WR) && out_free;

  // a link never written still holds its reset chain value: the next entry
  assign next_link = next_vld_rd_r ? next_rd_r
                                   : lbq_pkg::slot_t'(next_raddr_r + lbq_pkg::slot_t'(1));

  // scan: lowest set bit, bitmap reversed for the maximum side
  always_comb begin
    for (int i = 0; i < lbq_pkg::LEVELS; i++) begin
      scan_in[i] = (req_r == lbq_pkg::REQ_TAKE_MAX) ? bitmap_r[lbq_pkg::LEVELS-1-i]
                                                    : bitmap_r[i];
    end
    scan_idx = '0;
    for (int i = lbq_pkg::LEVELS - 1; i >= 0; i--) begin
      if (scan_in[i]) begin
        scan_idx = lbq_pkg::lvl_t'(i);
      end
    end
    scan_lvl = (req_r == lbq_pkg::REQ_TAKE_MAX)
               ? lbq_pkg::lvl_t'(lbq_pkg::lvl_t'(lbq_pkg::LEVELS - 1) - scan_idx)
               : scan_idx;
  end

  // read addresses stay fixed within a step so stalled data remain valid
  always_comb begin
    ht_raddr   = lvl_r;
    next_raddr = free_head_r;
    unique case (state_r) inside
      lbq_pkg::S_TAKE_HT: begin
        ht_raddr = found_r;
      end
      lbq_pkg::S_TAKE_ID, lbq_pkg::S_TAKE_WR: begin
        ht_raddr   = found_r;
        next_raddr = head_rd_r;
      end
      default: begin
        ht_raddr   = lvl_r;
        next_raddr = free_head_r;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lbq_pkg::S_IDLE: begin
        if (in_fire) state_nxt = lbq_pkg::S_DECODE;
      end
      lbq_pkg::S_DECODE: begin
        unique case (req_r) inside
          lbq_pkg::REQ_PUT: begin
            if (put_range || put_full) begin
              if (out_free) state_nxt = lbq_pkg::S_IDLE;
            end else begin
              state_nxt = lbq_pkg::S_PUT_WR;
            end
          end
          lbq_pkg::REQ_TAKE_MIN, lbq_pkg::REQ_TAKE_MAX: begin
            if (held_count_r != '0) begin
              state_nxt = lbq_pkg::S_TAKE_HT;
            end else if (out_free) begin
              state_nxt = lbq_pkg::S_IDLE;
            end
          end
          default: begin
            if (out_free) state_nxt = lbq_pkg::S_IDLE;
          end
        endcase
      end
      lbq_pkg::S_PUT_WR: begin
        if (out_free) state_nxt = lbq_pkg::S_IDLE;
      end
      lbq_pkg::S_TAKE_HT: state_nxt = lbq_pkg::S_TAKE_ID;
      lbq_pkg::S_TAKE_ID: state_nxt = lbq_pkg::S_TAKE_WR;
      lbq_pkg::S_TAKE_WR: begin
        if (out_free) state_nxt = lbq_pkg::S_IDLE;
      end
      default: state_nxt = lbq_pkg::S_IDLE;
    endcase
  end

  // datapath updates, memory writes and result per step
  always_comb begin
    bitmap_nxt     = bitmap_r;
    held_count_nxt = held_count_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    free_head_nxt  = free_head_r;
    res_load       = 1'b0;
    status_nxt     = lbq_pkg::ST_PUT_OK;
    oid_nxt        = '0;
    olvl_nxt       = '0;
    ocnt_nxt       = held_count_r;
    ids_we         = 1'b0;
    ids_waddr      = free_head_r;
    next_we        = 1'b0;
    next_waddr     = tail_rd_r;
    next_wdata     = free_head_r;
    head_we        = 1'b0;
    head_waddr     = lvl_r;
    head_wdata     = free_head_r;
    tail_we        = 1'b0;
    vld_clear      = 1'b0;

    unique case (state_r)
      lbq_pkg::S_DECODE: begin
        unique case (req_r) inside
          lbq_pkg::REQ_PUT: begin
            if (put_range) begin
              res_load   = out_free;
              status_nxt = lbq_pkg::ST_RANGE;
            end else if (put_full) begin
              res_load   = out_free;
              status_nxt = lbq_pkg::ST_FULL;
            end
          end
          lbq_pkg::REQ_TAKE_MIN, lbq_pkg::REQ_TAKE_MAX: begin
            if (held_count_r == '0) begin
              res_load   = out_free;
              status_nxt = lbq_pkg::ST_EMPTY;
            end
          end
          default: begin
            // clear: drop all lists and rebuild the free chain
            if (out_free) begin
              res_load       = 1'b1;
              bitmap_nxt     = '0;
              held_count_nxt = '0;
              low_nxt        = '0;
              high_nxt       = '0;
              free_head_nxt  = '0;
              vld_clear      = 1'b1;
              ocnt_nxt       = '0;
            end
          end
        endcase
      end

      lbq_pkg::S_PUT_WR: begin
        // append the free head entry to the tail of its level
        if (out_free) begin
          res_load      = 1'b1;
          free_head_nxt = next_link;
          ids_we        = 1'b1;
          ids_waddr     = free_head_r;
          tail_we       = 1'b1;
          if (bitmap_r[lvl_r]) begin
            next_we    = 1'b1;
            next_waddr = tail_rd_r;
            next_wdata = free_head_r;
          end else begin
            head_we    = 1'b1;
            head_waddr = lvl_r;
            head_wdata = free_head_r;
          end
          bitmap_nxt[lvl_r] = 1'b1;
          if (held_count_r == '0) begin
            low_nxt  = lvl_r;
            high_nxt = lvl_r;
          end else begin
            if (lvl_r < low_r)  low_nxt  = lvl_r;
            if (lvl_r > high_r) high_nxt = lvl_r;
          end
          held_count_nxt = lbq_pkg::cnt_t'(held_count_r + lbq_pkg::cnt_t'(1));
          ocnt_nxt       = held_count_nxt;
          status_nxt     = lbq_pkg::ST_PUT_OK;
        end
      end

      lbq_pkg::S_TAKE_WR: begin
        // pop the front entry of the found level and return it to the free chain
        if (out_free) begin
          res_load = 1'b1;
          if (head_rd_r == tail_rd_r) begin
            bitmap_nxt[found_r] = 1'b0;
          end else begin
            head_we    = 1'b1;
            head_waddr = found_r;
            head_wdata = next_link;
          end
          next_we        = 1'b1;
          next_waddr     = head_rd_r;
          next_wdata     = free_head_r;
          free_head_nxt  = head_rd_r;
          held_count_nxt = lbq_pkg::cnt_t'(held_count_r - lbq_pkg::cnt_t'(1));
          if (req_r == lbq_pkg::REQ_TAKE_MIN) begin
            low_nxt = found_r;
          end else begin
            high_nxt = found_r;
          end
          status_nxt = lbq_pkg::ST_TAKEN;
          oid_nxt    = ids_rd_r;
          olvl_nxt   = found_r;
          ocnt_nxt   = held_count_nxt;
        end
      end

      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lbq_pkg::S_IDLE;
      top_level_r  <= lbq_pkg::TOP_LEVEL_RST;
      bitmap_r     <= '0;
      held_count_r <= '0;
      low_r        <= '0;
      high_r       <= '0;
      free_head_r  <= '0;
      out_valid_r  <= 1'b0;
      next_vld_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      bitmap_r     <= bitmap_nxt;
      held_count_r <= held_count_nxt;
      low_r        <= low_nxt;
      high_r       <= high_nxt;
      free_head_r  <= free_head_nxt;
      if (cfg_we) top_level_r <= cfg_wdata;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (vld_clear) begin
        next_vld_r <= '0;
      end else if (next_we) begin
        next_vld_r[next_waddr] <= 1'b1;
      end
    end
  end

  // request capture, scan result and output beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_ch.req_type;
      lvl_r <= in_ch.item_level;
      id_r  <= in_ch.item_id;
    end
    if (state_r == lbq_pkg::S_DECODE) begin
      found_r <= scan_lvl;
    end
    if (res_load) begin
      status_r <= status_nxt;
      oid_r    <= oid_nxt;
      olvl_r   <= olvl_nxt;
      ocnt_r   <= ocnt_nxt;
    end
  end

  // entry store: identifiers
  always_ff @(posedge clk) begin
    if (ids_we) ids_mem[ids_waddr] <= id_r;
    ids_rd_r <= ids_mem[head_rd_r];
  end

  // entry store: links
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    next_rd_r     <= next_mem[next_raddr];
    next_vld_rd_r <= next_vld_r[next_raddr];
    next_raddr_r  <= next_raddr;
  end

  // level heads and tails
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (tail_we) tail_mem[lvl_r] <= free_head_r;
    head_rd_r <= head_mem[ht_raddr];
    tail_rd_r <= tail_mem[ht_raddr];
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.out_id     = oid_r;
  assign out_ch.out_level  = olvl_r;
  assign out_ch.item_count = ocnt_r;

  // checks
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= lbq_pkg::cnt_t'(lbq_pkg::CAPACITY))
    else $error("held count above capacity");

  a_map_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    (held_count_r == '0) == (bitmap_r == '0))
    else $error("level bitmap disagrees with held count");

  a_low_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (held_count_r != '0) |->
      ((bitmap_r & ((lbq_pkg::map_t'(1) << low_r) - lbq_pkg::map_t'(1))) == '0))
    else $error("occupied level below low bound");

  a_high_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (held_count_r != '0) |-> (((bitmap_r >> high_r) >> 1) == '0))
    else $error("occupied level above high bound");

  a_take_count: assert property (@(posedge clk) disable iff (!rst_n)
    take_commit |=> (held_count_r == lbq_pkg::cnt_t'($past(held_count_r) - 1'b1)))
    else $error("take did not lower the held count by one");

endmodule

>>> tb/sv/tb_top.sv
// Testbench for level_bucket_queue: directed and random requests checked against a queue predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    lbq_pkg::status_t status;
    lbq_pkg::id_t     id;
    lbq_pkg::lvl_t    level;
    lbq_pkg::cnt_t    count;
  } result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  lbq_pkg::lvl_t cfg_wdata;

  lbq_in_if  in_if ();
  lbq_out_if out_if ();

  level_bucket_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // Predicted state of the queue
  lbq_pkg::id_t   ids_store  [lbq_pkg::CAPACITY];
  lbq_pkg::slot_t link_store [lbq_pkg::CAPACITY];
  lbq_pkg::slot_t head_of    [lbq_pkg::LEVELS];
  lbq_pkg::slot_t tail_of    [lbq_pkg::LEVELS];
  lbq_pkg::map_t  occupied;
  int             held;
  lbq_pkg::lvl_t  lo_bound;
  lbq_pkg::lvl_t  hi_bound;
  lbq_pkg::slot_t free_slot;
  lbq_pkg::lvl_t  top_lvl;

  result_t due_results[$];
  int      mismatch_count = 0;
  bit      steady = 1'b0;

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Empty every level and rebuild the free chain
  function automatic void empty_queue();
    for (int i = 0; i < lbq_pkg::CAPACITY; i++) link_store[i] = lbq_pkg::slot_t'(i + 1);
    occupied  = '0;
    free_slot = '0;
    held      = 0;
    lo_bound  = '0;
    hi_bound  = '0;
  endfunction

  // Apply one request to the predicted queue and return the result it gives
  function automatic result_t bucket_apply(input lbq_pkg::req_t kind,
                                           input lbq_pkg::lvl_t lvl,
                                           input lbq_pkg::id_t id);
    result_t        res;
    lbq_pkg::slot_t slot;
    int             found;
    res.status = lbq_pkg::ST_EMPTY;
    res.id     = '0;
    res.level  = '0;
    found      = -1;
    case (kind) inside
      lbq_pkg::REQ_PUT: begin
        if (lvl > top_lvl) begin
          res.status = lbq_pkg::ST_RANGE;
        end else if (held >= lbq_pkg::CAPACITY) begin
          res.status = lbq_pkg::ST_FULL;
        end else begin
          slot = free_slot;
          free_slot = link_store[slot];
          ids_store[slot] = id;
          link_store[slot] = '0;
          if (occupied[lvl]) link_store[tail_of[lvl]] = slot;
          else head_of[lvl] = slot;
          tail_of[lvl] = slot;
          occupied[lvl] = 1'b1;
          if (held == 0) begin
            lo_bound = lvl;
            hi_bound = lvl;
          end else begin
            if (lvl < lo_bound) lo_bound = lvl;
            if (lvl > hi_bound) hi_bound = lvl;
          end
          held++;
          res.status = lbq_pkg::ST_PUT_OK;
        end
      end
      lbq_pkg::REQ_TAKE_MIN, lbq_pkg::REQ_TAKE_MAX: begin
        // Scan between the bounds; the descending scan stops at the low bound
        if (held > 0) begin
          if (kind == lbq_pkg::REQ_TAKE_MIN) begin
            for (int k = int'(lo_bound); k <= int'(hi_bound); k++)
              if (occupied[k]) begin
                found = k;
                break;
              end
          end else begin
            for (int k = int'(hi_bound); k >= int'(lo_bound); k--)
              if (occupied[k]) begin
                found = k;
                break;
              end
          end
        end
        if (found >= 0) begin
          slot = head_of[found];
          res.id = ids_store[slot];
          if (slot == tail_of[found]) occupied[found] = 1'b0;
          else head_of[found] = link_store[slot];
          link_store[slot] = free_slot;
          free_slot = slot;
          held--;
          res.level = lbq_pkg::lvl_t'(found);
          if (kind == lbq_pkg::REQ_TAKE_MIN) lo_bound = lbq_pkg::lvl_t'(found);
          else hi_bound = lbq_pkg::lvl_t'(found);
          res.status = lbq_pkg::ST_TAKEN;
        end
      end
      default: begin
        empty_queue();
        res.status = lbq_pkg::ST_PUT_OK;
      end
    endcase
    res.count = lbq_pkg::cnt_t'(held);
    return res;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Put level: mostly within top_level, sometimes anywhere
  function automatic lbq_pkg::lvl_t pick_level();
    if ($urandom_range(0, 9) == 0)
      return lbq_pkg::lvl_t'($urandom_range(0, lbq_pkg::LEVELS - 1));
    return lbq_pkg::lvl_t'($urandom_range(0, top_lvl));
  endfunction

  // Drive one request beat and hold it until accepted
  task automatic send_req(input lbq_pkg::req_t kind, input lbq_pkg::lvl_t lvl,
                          input lbq_pkg::id_t id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.req_type   <= kind;
    in_if.item_level <= lvl;
    in_if.item_id    <= id;
    do @(posedge clk); while (!in_if.ready);
    due_results.insert(due_results.size(), bucket_apply(kind, lvl, id));
  endtask

  // Write top_level once the block has gone idle
  task automatic set_top_level(input lbq_pkg::lvl_t value);
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    top_lvl = value;
  endtask

  // Check each result beat against the oldest prediction; drive ready with random stalls
  initial begin : result_check
    result_t want;
    int      stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatch_count++;
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (out_if.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_if.status);
            mismatch_count++;
          end
          if (out_if.out_id !== want.id) begin
            $error("out_id mismatch: expected %0h, got %0h", want.id, out_if.out_id);
            mismatch_count++;
          end
          if (out_if.out_level !== want.level) begin
            $error("out_level mismatch: expected %0d, got %0d", want.level, out_if.out_level);
            mismatch_count++;
          end
          if (out_if.item_count !== want.count) begin
            $error("item_count mismatch: expected %0d, got %0d", want.count,
                   out_if.item_count);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0 && !steady) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Empty takes, level ordering, FIFO order within a level, stale bounds, clear
  task automatic test_directed();
    send_req(lbq_pkg::REQ_TAKE_MIN, 6'h3f, 16'hffff);
    send_req(lbq_pkg::REQ_TAKE_MAX, 6'h00, 16'h0000);
    send_req(lbq_pkg::REQ_PUT, 6'd0, 16'h0000);
    send_req(lbq_pkg::REQ_PUT, 6'd63, 16'hffff);
    send_req(lbq_pkg::REQ_PUT, 6'd63, 16'h5a5a);
    send_req(lbq_pkg::REQ_PUT, 6'd31, 16'h1234);
    send_req(lbq_pkg::REQ_PUT, 6'd0, 16'h8001);
    send_req(lbq_pkg::REQ_TAKE_MAX, 6'h2a, 16'hdead);
    send_req(lbq_pkg::REQ_TAKE_MAX, 6'h00, 16'h0000);
    send_req(lbq_pkg::REQ_TAKE_MIN, 6'h3f, 16'hffff);
    // high bound is stale here: scan down from 63 to find 31
    send_req(lbq_pkg::REQ_TAKE_MAX, 6'h00, 16'h0000);
    send_req(lbq_pkg::REQ_TAKE_MIN, 6'h00, 16'h0000);
    send_req(lbq_pkg::REQ_TAKE_MIN, 6'h00, 16'h0000);
    send_req(lbq_pkg::REQ_PUT, 6'd17, 16'haaaa);
    send_req(lbq_pkg::REQ_PUT, 6'd45, 16'h5555);
    send_req(lbq_pkg::REQ_CLEAR, 6'h3f, 16'hffff);
    send_req(lbq_pkg::REQ_TAKE_MAX, 6'h00, 16'h0000);
    // descending scan that ends at level zero
    send_req(lbq_pkg::REQ_PUT, 6'd0, 16'h00ff);
    send_req(lbq_pkg::REQ_TAKE_MAX, 6'h15, 16'h0f0f);
    send_req(lbq_pkg::REQ_PUT, 6'd63, 16'hff00);
    send_req(lbq_pkg::REQ_TAKE_MIN, 6'h00, 16'h0000);
  endtask

  // Puts against the lowest top_level and the one just below the highest
  task automatic test_top_level();
    set_top_level(6'd0);
    send_req(lbq_pkg::REQ_PUT, 6'd0, 16'h0101);
    send_req(lbq_pkg::REQ_PUT, 6'd1, 16'h0202);
    send_req(lbq_pkg::REQ_PUT, 6'd63, 16'h0303);
    set_top_level(6'd62);
    send_req(lbq_pkg::REQ_PUT, 6'd63, 16'h0404);
    send_req(lbq_pkg::REQ_PUT, 6'd62, 16'h0505);
    send_req(lbq_pkg::REQ_TAKE_MAX, 6'h00, 16'h0000);
    send_req(lbq_pkg::REQ_TAKE_MAX, 6'h00, 16'h0000);
    send_req(lbq_pkg::REQ_TAKE_MAX, 6'h00, 16'h0000);
  endtask

  // Fill to capacity, overflow, range check ahead of the full check, drain
  task automatic test_capacity();
    set_top_level(6'd63);
    send_req(lbq_pkg::REQ_CLEAR, 6'h00, 16'h0000);
    for (int i = 0; i < lbq_pkg::CAPACITY; i++)
      send_req(lbq_pkg::REQ_PUT, lbq_pkg::lvl_t'($urandom_range(0, lbq_pkg::LEVELS - 1)),
               lbq_pkg::id_t'($urandom));
    send_req(lbq_pkg::REQ_PUT, 6'd20, lbq_pkg::id_t'($urandom));
    set_top_level(6'd10);
    send_req(lbq_pkg::REQ_PUT, 6'd40, lbq_pkg::id_t'($urandom));
    send_req(lbq_pkg::REQ_PUT, 6'd5, lbq_pkg::id_t'($urandom));
    for (int i = 0; i <= lbq_pkg::CAPACITY; i++)
      send_req(lbq_pkg::req_t'($urandom_range(0, 1) ? lbq_pkg::REQ_TAKE_MIN
                                                    : lbq_pkg::REQ_TAKE_MAX),
               lbq_pkg::lvl_t'($urandom), lbq_pkg::id_t'($urandom));
  endtask

  // Random mix of requests at the current top_level
  task automatic run_mix(input int items, input int put_pct);
    int r;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 999);
      if (r < 8)
        send_req(lbq_pkg::REQ_CLEAR, lbq_pkg::lvl_t'($urandom), lbq_pkg::id_t'($urandom));
      else if ($urandom_range(0, 99) < put_pct)
        send_req(lbq_pkg::REQ_PUT, pick_level(), lbq_pkg::id_t'($urandom));
      else if ($urandom_range(0, 1))
        send_req(lbq_pkg::REQ_TAKE_MIN, lbq_pkg::lvl_t'($urandom), lbq_pkg::id_t'($urandom));
      else
        send_req(lbq_pkg::REQ_TAKE_MAX, lbq_pkg::lvl_t'($urandom), lbq_pkg::id_t'($urandom));
    end
  endtask

  // Random phases over several top_level settings, one without any idling
  task automatic test_random_phases();
    set_top_level(6'd63);
    run_mix(300, 70);
    set_top_level(6'd0);
    run_mix(150, 55);
    set_top_level(lbq_pkg::lvl_t'($urandom));
    run_mix(250, 50);
    set_top_level(6'd63);
    run_mix(250, 35);
    set_top_level(6'd31);
    steady = 1'b1;
    run_mix(200, 55);
    steady = 1'b0;
    set_top_level(lbq_pkg::lvl_t'($urandom_range(1, 62)));
    run_mix(140, 60);
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.req_type   <= lbq_pkg::REQ_PUT;
    in_if.item_level <= '0;
    in_if.item_id    <= '0;
    empty_queue();
    for (int i = 0; i < lbq_pkg::CAPACITY; i++) ids_store[i] = '0;
    for (int i = 0; i < lbq_pkg::LEVELS; i++) begin
      head_of[i] = '0;
      tail_of[i] = '0;
    end
    top_lvl = lbq_pkg::TOP_LEVEL_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_top_level();
    test_capacity();
    test_random_phases();

    // Drain outstanding results, then allow for trailing beats
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Hang guard
  initial begin
    #(30ms);
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/lbq_pkg.sv
rtl/lbq_in_if.sv
rtl/lbq_out_if.sv
rtl/level_bucket_queue.sv
tb/sv/tb_top.sv
